>>> rtl/ggd_pkg.sv
// Package for the gripper grasp detector: phase codes, command codes,
// register indexes and the item, result and register structs.
// No dependencies.
package ggd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_BLIND    = 3'd1,
		PH_CLOSING  = 3'd2,
		PH_GRASPED  = 3'd3,
		PH_STALLED  = 3'd4,
		PH_TIMEOUT  = 3'd5,
		PH_READFAIL = 3'd6,
		PH_BADCFG   = 3'd7
	} phase_t;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	localparam logic [2:0] CFG_CURRENT_LIMIT = 3'd0;
	localparam logic [2:0] CFG_BLIND_TIME    = 3'd1;
	localparam logic [2:0] CFG_DEBOUNCE_TIME = 3'd2;
	localparam logic [2:0] CFG_POLL_PERIOD   = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT_TIME  = 3'd4;
	localparam logic [2:0] CFG_STALL_MASK    = 3'd5;

	localparam logic [15:0] DEFAULT_POLL    = 16'd20;
	localparam logic [15:0] DEFAULT_TIMEOUT = 16'd2000;
	localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
	localparam logic [16:0] SUM_MAX         = 17'h1FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] sample_current;
		logic        read_ok;
		logic [7:0]  flag_byte;
		logic        flags_ok;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        stop_motor;
		logic        poll_request;
		logic [15:0] touch_current;
	} result_t;

	typedef struct packed {
		logic [15:0] current_limit;
		logic [15:0] blind_time;
		logic [15:0] debounce_time;
		logic [15:0] poll_period;
		logic [15:0] timeout_time;
		logic [7:0]  stall_mask;
	} cfg_t;

endpackage

>>> rtl/ggd_item_if.sv
// Input item channel of the grasp detector: valid/ready plus the item fields.
// No dependencies.
interface ggd_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] sample_current;
	logic        read_ok;
	logic [7:0]  flag_byte;
	logic        flags_ok;

	modport source (output valid, command, sample_current, read_ok, flag_byte, flags_ok,
		input ready);
	modport sink (input valid, command, sample_current, read_ok, flag_byte, flags_ok,
		output ready);
endinterface

>>> rtl/ggd_result_if.sv
// Result channel of the grasp detector: valid/ready plus the result fields.
// No dependencies.
interface ggd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        stop_motor;
	logic        poll_request;
	logic [15:0] touch_current;

	modport source (output valid, status, stop_motor, poll_request, touch_current,
		input ready);
	modport sink (input valid, status, stop_motor, poll_request, touch_current,
		output ready);
endinterface

>>> rtl/ggd_cfg_if.sv
// Register write channel of the grasp detector: valid/ready, index, data.
// No dependencies.
interface ggd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ggd_cfg_regs.sv
// Configuration register file of the grasp detector.
// Depends on ggd_pkg and ggd_cfg_if.
module ggd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	ggd_cfg_if.sink       cfg,
	output ggd_pkg::cfg_t regs
);
	import ggd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.current_limit <= 16'd500;
			regs_q.blind_time    <= 16'd60;
			regs_q.debounce_time <= 16'd40;
			regs_q.poll_period   <= 16'd10;
			regs_q.timeout_time  <= 16'd4500;
			regs_q.stall_mask    <= 8'd12;
		end else if (cfg.valid) begin
			// indexes past the list are dropped
			unique case (cfg.index)
				CFG_CURRENT_LIMIT: regs_q.current_limit <= cfg.data;
				CFG_BLIND_TIME:    regs_q.blind_time    <= cfg.data;
				CFG_DEBOUNCE_TIME: regs_q.debounce_time <= cfg.data;
				CFG_POLL_PERIOD:   regs_q.poll_period   <= cfg.data;
				CFG_TIMEOUT_TIME:  regs_q.timeout_time  <= cfg.data;
				CFG_STALL_MASK:    regs_q.stall_mask    <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end
endmodule

>>> rtl/ggd_core.sv
// Grasp state and its single-pass update for one item.
// Depends on ggd_pkg.
module ggd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ggd_pkg::item_t   item,
	input  ggd_pkg::cfg_t    regs,
	output ggd_pkg::result_t res
);
	import ggd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [15:0] poll_timer_q, poll_timer_d;
	logic [16:0] debounce_q, debounce_d;
	logic [15:0] last_current_q, last_current_d;
	logic        stop, poll;

	logic [15:0] eff_poll, eff_timeout, elapsed_inc, poll_inc;
	logic [17:0] sum_ext;
	logic [16:0] sum_sat;

	assign eff_poll    = (regs.poll_period == 16'd0) ? DEFAULT_POLL : regs.poll_period;
	assign eff_timeout = (regs.timeout_time == 16'd0) ? DEFAULT_TIMEOUT : regs.timeout_time;
	assign elapsed_inc = (elapsed_q == COUNT_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign poll_inc    = (poll_timer_q == COUNT_MAX) ? poll_timer_q : poll_timer_q + 16'd1;
	assign sum_ext     = {1'b0, debounce_q} + {2'b00, eff_poll};
	assign sum_sat     = sum_ext[17] ? SUM_MAX : sum_ext[16:0];

	always_comb begin
		phase_d        = phase_q;
		elapsed_d      = elapsed_q;
		poll_timer_d   = poll_timer_q;
		debounce_d     = debounce_q;
		last_current_d = last_current_q;
		stop           = 1'b0;
		poll           = 1'b0;
		if (item.command == CMD_START) begin
			elapsed_d      = '0;
			poll_timer_d   = '0;
			debounce_d     = '0;
			last_current_d = '0;
			if (regs.current_limit == 16'd0) begin
				phase_d = PH_BADCFG;
			end else if (regs.blind_time == 16'd0) begin
				phase_d = PH_CLOSING;
				poll    = 1'b1;
			end else begin
				phase_d = PH_BLIND;
			end
		end else if (item.command == CMD_TICK) begin
			if (phase_q == PH_BLIND) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= regs.blind_time) begin
					phase_d      = PH_CLOSING;
					elapsed_d    = '0;
					poll_timer_d = '0;
					poll         = 1'b1;
				end
			end else if (phase_q == PH_CLOSING) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= eff_timeout) begin
					phase_d = PH_TIMEOUT;
					stop    = 1'b1;
				end else if (poll_inc >= eff_poll) begin
					poll_timer_d = '0;
					poll         = 1'b1;
				end else begin
					poll_timer_d = poll_inc;
				end
			end
		end else if (item.command == CMD_SAMPLE && phase_q == PH_CLOSING) begin
			if (!item.read_ok) begin
				phase_d = PH_READFAIL;
				stop    = 1'b1;
			end else begin
				last_current_d = item.sample_current;
				if (item.flags_ok && (item.flag_byte & regs.stall_mask) != 8'd0) begin
					phase_d = PH_STALLED;
					stop    = 1'b1;
				end else if (item.sample_current >= regs.current_limit) begin
					debounce_d = sum_sat;
					if (sum_sat >= {1'b0, regs.debounce_time}) begin
						phase_d = PH_GRASPED;
						stop    = 1'b1;
					end
				end else begin
					debounce_d = '0;
				end
			end
		end
	end

	assign res.status        = phase_d;
	assign res.stop_motor    = stop;
	assign res.poll_request  = poll;
	assign res.touch_current = last_current_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			elapsed_q      <= '0;
			poll_timer_q   <= '0;
			debounce_q     <= '0;
			last_current_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			elapsed_q      <= elapsed_d;
			poll_timer_q   <= poll_timer_d;
			debounce_q     <= debounce_d;
			last_current_q <= last_current_d;
		end
	end
endmodule

>>> rtl/gripper_grasp_detector.sv
// Top level of the gripper grasp detector: input register, state update,
// result register and handshake. Depends on ggd_pkg, the three channel
// interfaces, ggd_cfg_regs and ggd_core.
//
//   channel  dir  word
//   item     in   command, sample_current, read_ok, flag_byte, flags_ok
//   result   out  status, stop_motor, poll_request, touch_current
//   cfg      in   index, data (always ready)
//
// Each accepted word gives one result from the input register through the
// state update to the result register; one word per cycle is taken sustained
// while results are taken. Reset puts the registers at their defaults and
// the phase at idle. A stalled result holds the input register, and item.ready
// drops only when both registers are full and the result is not taken.
module gripper_grasp_detector (
	input  logic       clk,
	input  logic       arst_n,
	ggd_item_if.sink   item,
	ggd_result_if.source result,
	ggd_cfg_if.sink    cfg
);
	import ggd_pkg::*;

	cfg_t    regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb, result_s2;
	logic    valid_s2;
	logic    out_free, advance, item_acc;

	assign out_free   = !valid_s2 || result.ready;
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || advance;
	assign item_acc   = item.valid && item.ready;

	ggd_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (regs)
	);

	ggd_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.regs  (regs),
		.res   (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1.command        <= item.command;
			item_s1.sample_current <= item.sample_current;
			item_s1.read_ok        <= item.read_ok;
			item_s1.flag_byte      <= item.flag_byte;
			item_s1.flags_ok       <= item.flags_ok;
		end
		if (advance) begin
			result_s2 <= res_comb;
		end
	end

	assign result.valid         = valid_s2;
	assign result.status        = result_s2.status;
	assign result.stop_motor    = result_s2.stop_motor;
	assign result.poll_request  = result_s2.poll_request;
	assign result.touch_current = result_s2.touch_current;

	// a stop pulse only comes with one of the four ending phases
	a_stop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.stop_motor |->
			result_s2.status == PH_GRASPED || result_s2.status == PH_STALLED ||
			result_s2.status == PH_TIMEOUT || result_s2.status == PH_READFAIL)
		else $error("stop pulse outside an ending phase");

	// samples are only asked for while closing
	a_poll_closing: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.poll_request |-> result_s2.status == PH_CLOSING)
		else $error("poll request outside closing");

	// a held input word stays put while the result side is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled word");

	// never both registers full with ready still high
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result.ready |-> !item.ready)
		else $error("item accepted with no room");
endmodule

>>> test/gripper_grasp_detector_tb.sv
// Testbench for gripper_grasp_detector: directed and random sensor events,
// random stalls on both channels, predicted results checked word by word.
// Depends on ggd_pkg, the three channel interfaces and the RTL of the block.
module gripper_grasp_detector_tb;
	import ggd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 75;
	localparam int DRAIN_POINT = 30;

	typedef struct {
		item_t it;
		bit    drain;
	} sensor_event_t;

	logic clk;
	logic arst_n;

	ggd_item_if   item_ch ();
	ggd_result_if res_ch ();
	ggd_cfg_if    cfg_ch ();

	gripper_grasp_detector i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// register copy and detector state as seen by the predictor
	cfg_t        regs;
	phase_t      ph;
	logic [15:0] elapsed;
	logic [15:0] poll_t;
	logic [16:0] dsum;
	logic [15:0] last_cur;

	sensor_event_t sensor_events_q[$];
	result_t       detector_out_q[$];
	sensor_event_t ev;

	bit item_taken, res_taken, cfg_taken;
	int n_driven, n_taken;
	int snd_gap, rcv_wait;
	bit snd_burst, rcv_burst;
	int idle_cycles;
	int mismatches;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic result_t grasp_predict(item_t it);
		logic [15:0] ep;
		logic [15:0] et;
		logic [17:0] sum_n;
		result_t     r;
		ep = (regs.poll_period == '0) ? DEFAULT_POLL : regs.poll_period;
		et = (regs.timeout_time == '0) ? DEFAULT_TIMEOUT : regs.timeout_time;
		r = '0;
		case (it.command)
			CMD_START: begin
				elapsed = '0;
				poll_t = '0;
				dsum = '0;
				last_cur = '0;
				if (regs.current_limit == '0) begin
					ph = PH_BADCFG;
				end else if (regs.blind_time == '0) begin
					ph = PH_CLOSING;
					r.poll_request = 1'b1;
				end else begin
					ph = PH_BLIND;
				end
			end
			CMD_TICK: begin
				if (ph == PH_BLIND) begin
					if (elapsed != COUNT_MAX) elapsed++;
					if (elapsed >= regs.blind_time) begin
						ph = PH_CLOSING;
						elapsed = '0;
						poll_t = '0;
						r.poll_request = 1'b1;
					end
				end else if (ph == PH_CLOSING) begin
					if (elapsed != COUNT_MAX) elapsed++;
					if (elapsed >= et) begin
						ph = PH_TIMEOUT;
						r.stop_motor = 1'b1;
					end else begin
						if (poll_t != COUNT_MAX) poll_t++;
						if (poll_t >= ep) begin
							poll_t = '0;
							r.poll_request = 1'b1;
						end
					end
				end
			end
			CMD_SAMPLE: begin
				if (ph == PH_CLOSING) begin
					if (!it.read_ok) begin
						ph = PH_READFAIL;
						r.stop_motor = 1'b1;
					end else begin
						last_cur = it.sample_current;
						if (it.flags_ok && (it.flag_byte & regs.stall_mask) != '0) begin
							ph = PH_STALLED;
							r.stop_motor = 1'b1;
						end else if (it.sample_current >= regs.current_limit) begin
							sum_n = {1'b0, dsum} + ep;
							dsum = (sum_n > SUM_MAX) ? SUM_MAX : sum_n[16:0];
							if (dsum >= {1'b0, regs.debounce_time}) begin
								ph = PH_GRASPED;
								r.stop_motor = 1'b1;
							end
						end else begin
							dsum = '0;
						end
					end
				end
			end
			default: ;
		endcase
		r.status = ph;
		r.touch_current = last_cur;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 100)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// sampling side: result check, prediction of accepted words, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			item_taken = item_ch.valid && item_ch.ready;
			res_taken = res_ch.valid && res_ch.ready;
			cfg_taken = cfg_ch.valid && cfg_ch.ready;
			if (res_taken) begin
				if (detector_out_q.size() == 0) begin
					report_mismatch("result word with none due", res_ch.status, 0);
				end else begin
					result_t want;
					want = detector_out_q.pop_front();
					if (res_ch.status !== want.status)
						report_mismatch("status", res_ch.status, want.status);
					if (res_ch.stop_motor !== want.stop_motor)
						report_mismatch("stop_motor", res_ch.stop_motor, want.stop_motor);
					if (res_ch.poll_request !== want.poll_request)
						report_mismatch("poll_request", res_ch.poll_request,
							want.poll_request);
					if (res_ch.touch_current !== want.touch_current)
						report_mismatch("touch_current", res_ch.touch_current,
							want.touch_current);
				end
			end
			if (item_taken) begin
				detector_out_q.push_back(grasp_predict({item_ch.command,
					item_ch.sample_current, item_ch.read_ok, item_ch.flag_byte,
					item_ch.flags_ok}));
				n_taken++;
			end
			if (item_taken || res_taken || cfg_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_ch.valid || item_taken) begin
				if (snd_gap > 0) begin
					item_ch.valid <= 1'b0;
					snd_gap--;
				end else if (sensor_events_q.size() != 0 &&
						!(sensor_events_q[0].drain && detector_out_q.size() != 0)) begin
					ev = sensor_events_q.pop_front();
					item_ch.command <= ev.it.command;
					item_ch.sample_current <= ev.it.sample_current;
					item_ch.read_ok <= ev.it.read_ok;
					item_ch.flag_byte <= ev.it.flag_byte;
					item_ch.flags_ok <= ev.it.flags_ok;
					item_ch.valid <= 1'b1;
					n_driven++;
					snd_gap = snd_burst ? 0 : $urandom_range(0, 10);
					if ($urandom_range(0, 39) == 0) snd_burst = !snd_burst;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				rcv_wait = rcv_burst ? 0 : $urandom_range(0, 10);
				if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
			end
			if (rcv_wait > 0) begin
				res_ch.ready <= 1'b0;
				rcv_wait--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_item(input logic [1:0] cmd, input logic [15:0] cur,
			input logic rok, input logic [7:0] flags, input logic fok, input bit drain);
		sensor_event_t e;
		e.it = {cmd, cur, rok, flags, fok};
		e.drain = drain;
		sensor_events_q.push_back(e);
	endtask

	// called at a falling edge; returns at the falling edge after the write
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(negedge clk); while (!cfg_taken);
		case (idx)
			CFG_CURRENT_LIMIT: regs.current_limit = val;
			CFG_BLIND_TIME:    regs.blind_time = val;
			CFG_DEBOUNCE_TIME: regs.debounce_time = val;
			CFG_POLL_PERIOD:   regs.poll_period = val;
			CFG_TIMEOUT_TIME:  regs.timeout_time = val;
			CFG_STALL_MASK:    regs.stall_mask = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [15:0] lim, input logic [15:0] blind,
			input logic [15:0] deb, input logic [15:0] poll, input logic [15:0] tmo,
			input logic [7:0] mask);
		write_reg(CFG_CURRENT_LIMIT, lim);
		write_reg(CFG_BLIND_TIME, blind);
		write_reg(CFG_DEBOUNCE_TIME, deb);
		write_reg(CFG_POLL_PERIOD, poll);
		write_reg(CFG_TIMEOUT_TIME, tmo);
		write_reg(CFG_STALL_MASK, {8'd0, mask});
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (sensor_events_q.size() != 0 || detector_out_q.size() != 0 ||
			n_driven != n_taken);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_reg(input int lo, input int hi);
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	// currents clustered round the threshold, plus the extremes
	function automatic logic [15:0] pick_current();
		int c;
		case ($urandom_range(0, 5))
			0: c = int'(regs.current_limit);
			1: c = int'(regs.current_limit) - 1;
			2: c = int'(regs.current_limit) + int'($urandom_range(0, 50));
			3: c = 0;
			4: c = 65535;
			default: c = int'($urandom_range(0, 16'hFFFF));
		endcase
		if (c > 65535) c = 65535;
		if (c < 0) c = 65535;
		return 16'(c);
	endfunction

	task automatic gen_random(input int n);
		int k, len, r;
		logic [7:0] fl;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: any field, any command
				len = $urandom_range(3, 10);
				repeat (len) begin
					push_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
						1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), k == DRAIN_POINT);
					k++;
				end
			end else begin
				push_item(CMD_START, 16'($urandom_range(0, 16'hFFFF)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), k == DRAIN_POINT);
				k++;
				len = $urandom_range(5, 40);
				repeat (len) begin
					r = $urandom_range(0, 99);
					fl = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
					if (r < 60)
						push_item(CMD_TICK, 16'($urandom_range(0, 16'hFFFF)),
							1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), k == DRAIN_POINT);
					else if (r < 95)
						push_item(CMD_SAMPLE, pick_current(),
							$urandom_range(0, 19) != 0, fl, 1'($urandom_range(0, 1)),
							k == DRAIN_POINT);
					else if (r < 98)
						push_item(CMD_UNUSED, 16'($urandom_range(0, 16'hFFFF)),
							1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), k == DRAIN_POINT);
					else
						push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, k == DRAIN_POINT);
					k++;
				end
			end
		end
	endtask

	initial begin
		logic [7:0] mask;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_START;
		item_ch.sample_current = '0;
		item_ch.read_ok = 1'b0;
		item_ch.flag_byte = '0;
		item_ch.flags_ok = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CURRENT_LIMIT;
		cfg_ch.data = '0;
		regs = '{current_limit: 16'd500, blind_time: 16'd60, debounce_time: 16'd40,
			poll_period: 16'd10, timeout_time: 16'd4500, stall_mask: 8'd12};
		ph = PH_IDLE;
		elapsed = '0;
		poll_t = '0;
		dsum = '0;
		last_cur = '0;
		item_taken = 0;
		res_taken = 0;
		cfg_taken = 0;
		n_driven = 0;
		n_taken = 0;
		snd_gap = 0;
		rcv_wait = 0;
		snd_burst = 0;
		rcv_burst = 0;
		idle_cycles = 0;
		mismatches = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: blind, debounce, grasp, read failure, stall, unused command
		write_all(16'd100, 16'd2, 16'd6, 16'd3, 16'd30, 8'h0C);
		push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd500, 1'b1, 8'd0, 1'b1, 0);   // ignored while blind
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd100, 1'b1, 8'd0, 1'b1, 0);
		push_item(CMD_SAMPLE, 16'd99, 1'b1, 8'd0, 1'b1, 0);    // clears the sum
		push_item(CMD_SAMPLE, 16'hFFFF, 1'b1, 8'd0, 1'b1, 0);
		push_item(CMD_SAMPLE, 16'd200, 1'b1, 8'hFF, 1'b0, 0);  // bad flag read ignored
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd300, 1'b1, 8'd0, 1'b1, 0);
		push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd300, 1'b0, 8'd0, 1'b1, 0);
		push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd5, 1'b1, 8'h04, 1'b1, 0);
		push_item(CMD_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 0);
		wait_idle();

		// zero threshold
		write_all(16'd0, 16'd2, 16'd6, 16'd3, 16'd30, 8'h0C);
		push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		wait_idle();

		// no blind period, default poll period, short timeout, zero debounce
		write_all(16'd1, 16'd0, 16'd0, 16'd0, 16'd3, 8'hFF);
		push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd0, 1'b1, 8'h00, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_START, 16'd0, 1'b0, 8'd0, 1'b0, 0);
		push_item(CMD_SAMPLE, 16'd1, 1'b1, 8'h00, 1'b1, 0);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				write_all(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
			end else if (p == 1) begin
				write_all(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
			end else begin
				case ($urandom_range(0, 3))
					0: mask = 8'h00;
					1: mask = 8'hFF;
					default: mask = 8'($urandom_range(0, 255));
				endcase
				write_all(pick_reg(1, 1200), pick_reg(0, 6), pick_reg(0, 40),
					pick_reg(1, 8), pick_reg(1, 80), mask);
			end
			gen_random(PHASE_ITEMS);
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0 && detector_out_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
